// File: rtl/core/cell_integral_sine_product_unit_defines.svh
// Assertion macros shared by the cell integral sine product unit.
`ifndef CELL_INTEGRAL_SINE_PRODUCT_UNIT_DEFINES_SVH
`define CELL_INTEGRAL_SINE_PRODUCT_UNIT_DEFINES_SVH

// Implication checked in the same cycle, clocked on clk and held off during reset.
`define CSP_ASSERT_IMPLY(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define CSP_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/csp_pkg.sv
// Package with types, constants and helper functions of the cell integral sine product unit.
`default_nettype none

package csp_pkg;

	localparam int MAX_CELLS_DEF = 64;
	localparam int CORDIC_STEPS = 30;
	localparam int TrigW = 34;

	localparam logic [46:0] TWO_PI_Q44 = 47'h6487ED5110B5;
	localparam logic signed [TrigW-1:0] PI_Q30 = 34'sd3373259426;
	localparam logic signed [TrigW-1:0] TWO_PI_Q30 = 34'sd6746518852;
	localparam logic signed [TrigW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [TrigW-1:0] QUARTER_PI_Q30 = 34'sd843314857;
	localparam logic signed [TrigW-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	// Evaluation points of the setup: u0, u0+du, u0+2du and the step du itself.
	localparam logic [1:0] EV_U0 = 2'd0;
	localparam logic [1:0] EV_U1 = 2'd1;
	localparam logic [1:0] EV_U2 = 2'd2;
	localparam logic [1:0] EV_DU = 2'd3;

	typedef logic signed [TrigW-1:0] atan_tab_t [CORDIC_STEPS];

	typedef struct packed {
		logic signed [31:0] start_angle;
		logic signed [31:0] step_angle;
		logic [6:0]         cell_count;
		logic signed [31:0] freq_one;
		logic signed [31:0] freq_two;
	} req_t;

	typedef struct packed {
		logic signed [31:0] integral;
		logic [5:0]         cell_index;
		logic               last;
	} res_t;

	typedef enum logic [1:0] {
		MODE_ZERO    = 2'd0,
		MODE_EQUAL   = 2'd1,
		MODE_GENERAL = 2'd2
	} mode_t;

	typedef struct packed {
		logic       load;
		logic       trig_start;
		logic       trig_store;
		logic       track;
		logic [1:0] ev;
		logic       mul;
		logic       recur;
		logic       div_start;
		logic       div_take;
		logic       first;
		logic       emit;
		logic [5:0] cell_idx;
		logic       last;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  trig_done;
		logic  div_done;
	} sts_t;

	// Unsigned quotient by restoring long division, only used while building constants.
	function automatic longint udiv_const(input longint a, input longint b);
		longint q;
		longint r;
		int i;
		q = 0;
		r = 0;
		for (i = 62; i >= 0; i--) begin
			r = (r <<< 1) | ((a >>> i) & longint'(1));
			if (r >= b) begin
				r = r - b;
				q = q | (longint'(1) <<< i);
			end
		end
		return q;
	endfunction

	// Arctangents of 2^-i in Q30, from the odd power series evaluated in Q62.
	function automatic atan_tab_t build_atan();
		atan_tab_t tab;
		longint acc;
		longint term;
		int i;
		int n;
		tab[0] = QUARTER_PI_Q30;
		for (i = 1; i < CORDIC_STEPS; i++) begin
			acc = 0;
			for (n = 0; i * (2 * n + 1) <= 62; n++) begin
				term = udiv_const(longint'(1) <<< (62 - i * (2 * n + 1)),
					longint'(2 * n + 1));
				acc = n[0] ? acc - term : acc + term;
			end
			tab[i] = TrigW'((acc + (longint'(1) <<< 31)) >>> 32);
		end
		return tab;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();

	// Clamp a Q30 value to the range -2 .. 2.
	function automatic logic signed [32:0] clamp2(input logic signed [39:0] v);
		if (v > 40'sd2147483648)
			return 33'sd2147483648;
		if (v < -40'sd2147483648)
			return -33'sd2147483648;
		return 33'(v);
	endfunction

	// Saturate to the signed 32-bit range.
	function automatic logic signed [31:0] sat32(input logic signed [44:0] v);
		if (v > 45'sd2147483647)
			return 32'sh7FFFFFFF;
		if (v < -45'sd2147483648)
			return 32'sh80000000;
		return 32'(v);
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/cell_integral_sine_product_unit.sv
// Top level of the cell integral sine product unit: controller, datapath and checks.
`default_nettype none
`include "cell_integral_sine_product_unit_defines.svh"

// Channel      Direction  Signals                    Beat taken when
// request      in         start, busy, request       start high and busy low
// result       out        strobe, result             strobe high, one cycle, no stall
// config       in         cfg_we, cfg_data           cfg_we high
//
// Each request computes, once, sines at the three cell edges u0, u0+du, u0+2du and the
// cosine of the step for one frequency track (equal mode) or two (general mode). One
// evaluation runs a start step, the bit-serial phase reduction modulo 2pi, sign fix,
// rounding and folding, 30 CORDIC rotations and a store. Each cell then takes one
// division per track, and from the third cell on a multiply and a recurrence step per
// track before its divisions; in the zero mode a cell only emits its result beat.
// Reset clears the controller, the unit sequencers and the threshold (to 1); the
// result side cannot stall, so every result beat is shown exactly once.

module cell_integral_sine_product_unit import csp_pkg::*; #(
	parameter int MAX_CELLS = MAX_CELLS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire req_t        request,
	output logic             strobe,
	output res_t             result,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data
);

	// Commands from the controller and status back from the datapath.
	cmd_t cmd;
	sts_t sts;

	csp_ctrl #(
		.MAX_CELLS (MAX_CELLS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.cell_count (request.cell_count),
		.sts        (sts),
		.busy       (busy),
		.cmd        (cmd)
	);

	csp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.request  (request),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts),
		.strobe   (strobe),
		.result   (result)
	);

	// The final beat of a request leaves the unit idle.
	`CSP_ASSERT_IMPLY(a_last_idle, strobe && result.last, !busy, "last beat while still busy")
	// Result beats never come back to back.
	`CSP_ASSERT_NEXT(a_beat_gap, strobe, !strobe, "result beats back to back")
	// A result beat only follows a cycle in which a request was being worked on.
	`CSP_ASSERT_IMPLY(a_beat_busy, strobe, $past(busy), "result beat without a request")

endmodule

`default_nettype wire

// File: rtl/core/csp_trig.sv
// Sine and cosine of k*u: bit-serial modulo 2pi reduction followed by a 30-step CORDIC.
`default_nettype none

module csp_trig import csp_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [TrigW-1:0] k,
	input  wire logic signed [TrigW-1:0] u,
	output logic                         done,
	output logic signed [TrigW-1:0]      sn,
	output logic signed [TrigW-1:0]      cs
);

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_RED  = 6'b000010,
		PH_NEG  = 6'b000100,
		PH_RND  = 6'b001000,
		PH_FOLD = 6'b010000,
		PH_ROT  = 6'b100000
	} phase_t;

	localparam int RedSteps = 33;

	phase_t phase_q;
	logic [5:0] cnt_q;
	logic done_q;

	logic [32:0] ka_q, ua_q;
	logic neg_q, flip_q;
	logic [46:0] r_q;
	logic signed [TrigW-1:0] t_q, x_q, y_q, z_q;

	logic [32:0] ka_in, ua_in;
	logic [47:0] r2, r3;
	logic [46:0] r_red;
	logic [47:0] r_rnd;
	logic signed [TrigW-1:0] tw, tf;
	logic fl;
	logic signed [TrigW-1:0] dx, dy, at;

	assign ka_in = k[TrigW-1] ? 33'(-k) : 33'(k);
	assign ua_in = u[TrigW-1] ? 33'(-u) : 33'(u);

	// One Horner step: r = (2r + bit*|k|) mod 2pi, both partial sums below twice the modulus.
	always_comb begin
		r2 = {r_q, 1'b0};
		if (r2 >= {1'b0, TWO_PI_Q44})
			r2 = r2 - {1'b0, TWO_PI_Q44};
		r3 = ua_q[32] ? r2 + {15'b0, ka_q} : r2;
		if (r3 >= {1'b0, TWO_PI_Q44})
			r3 = r3 - {1'b0, TWO_PI_Q44};
		r_red = r3[46:0];
	end

	assign r_rnd = {1'b0, r_q} + 48'd8192;

	always_comb begin
		tw = (t_q > PI_Q30) ? t_q - TWO_PI_Q30 : t_q;
		fl = 1'b0;
		tf = tw;
		if (tw > HALF_PI_Q30) begin
			tf = PI_Q30 - tw;
			fl = 1'b1;
		end else if (tw < -HALF_PI_Q30) begin
			tf = -PI_Q30 - tw;
			fl = 1'b1;
		end
	end

	assign dx = y_q >>> cnt_q[4:0];
	assign dy = x_q >>> cnt_q[4:0];
	assign at = ATAN_TAB[cnt_q[4:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (phase_q)
				PH_IDLE: begin
					if (start) begin
						phase_q <= PH_RED;
						cnt_q   <= '0;
					end
				end
				PH_RED: begin
					if (cnt_q == 6'(RedSteps - 1))
						phase_q <= PH_NEG;
					else
						cnt_q <= cnt_q + 6'd1;
				end
				PH_NEG:  phase_q <= PH_RND;
				PH_RND:  phase_q <= PH_FOLD;
				PH_FOLD: begin
					phase_q <= PH_ROT;
					cnt_q   <= '0;
				end
				PH_ROT: begin
					if (cnt_q == 6'(CORDIC_STEPS - 1)) begin
						phase_q <= PH_IDLE;
						done_q  <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					ka_q  <= ka_in;
					ua_q  <= ua_in;
					neg_q <= k[TrigW-1] ^ u[TrigW-1];
					r_q   <= '0;
				end
			end
			PH_RED: begin
				r_q  <= r_red;
				ua_q <= {ua_q[31:0], 1'b0};
			end
			PH_NEG: begin
				if (neg_q && (r_q != '0))
					r_q <= TWO_PI_Q44 - r_q;
			end
			PH_RND:  t_q <= $signed(r_rnd[47:14]);
			PH_FOLD: begin
				x_q    <= CORDIC_GAIN_Q30;
				y_q    <= '0;
				z_q    <= tf;
				flip_q <= fl;
			end
			PH_ROT: begin
				if (!z_q[TrigW-1]) begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - at;
				end else begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + at;
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign sn   = y_q;
	assign cs   = flip_q ? -x_q : x_q;

endmodule

`default_nettype wire

// File: rtl/core/csp_div.sv
// Signed division rounded to nearest with halves away from zero, one quotient bit per cycle.
`default_nettype none

module csp_div import csp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [41:0] num,
	input  wire logic signed [33:0] den,
	output logic                    done,
	output logic signed [42:0]      quo
);

	localparam int DivSteps = 42;

	logic run_q, done_q;
	logic [5:0] cnt_q;
	logic [41:0] nq_q;
	logic [32:0] rem_q, ad_q;
	logic neg_q, zero_q;

	logic [41:0] an;
	logic [32:0] ad;
	logic [33:0] rem_sh;
	logic ge;

	assign an = num[41] ? 42'(-num) : 42'(num);
	assign ad = den[33] ? 33'(-den) : 33'(den);
	assign rem_sh = {rem_q, nq_q[41]};
	assign ge = rem_sh >= {1'b0, ad_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				if (cnt_q == 6'(DivSteps - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nq_q   <= an + 42'(ad >> 1);
			ad_q   <= ad;
			rem_q  <= '0;
			neg_q  <= num[41] ^ den[33];
			zero_q <= (ad == '0);
		end else if (run_q) begin
			rem_q <= ge ? 33'(rem_sh - {1'b0, ad_q}) : rem_sh[32:0];
			nq_q  <= {nq_q[40:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = zero_q ? '0 : (neg_q ? -$signed({1'b0, nq_q}) : $signed({1'b0, nq_q}));

endmodule

`default_nettype wire

// File: rtl/core/csp_dp.sv
// Datapath: request and threshold registers, the two sine tracks, trig and divide units, result register.
`default_nettype none

module csp_dp import csp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire req_t        request,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_data,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	output logic             strobe,
	output res_t             result
);

	logic [15:0] thr_q;
	logic signed [31:0] u0_q, du_q, a1_q, a2_q;
	logic signed [32:0] p0_q, q0_q, d0_q, p1_q, q1_q, d1_q;
	logic signed [TrigW-1:0] sprev_q;
	logic signed [65:0] prod_q;
	logic signed [42:0] qa_q;
	logic strobe_q;
	res_t res_q;

	logic signed [33:0] a1x, a2x, m1s, m2s, thrx, mdiff, mabs, kdiff, ksum;
	logic signed [33:0] u0x, dux, k_sel, u_sel, den, half;
	mode_t mode;
	logic signed [32:0] p_sel, q_sel, d_sel, s_sel, st_val, nx;
	logic signed [65:0] rnd;
	logic signed [41:0] num;
	logic signed [44:0] v1, v2, v;
	logic trig_done, div_done;
	logic signed [TrigW-1:0] sn, cs;
	logic signed [42:0] quo;

	assign a1x   = 34'(a1_q);
	assign a2x   = 34'(a2_q);
	assign m1s   = a1x[33] ? -a1x : a1x;
	assign m2s   = a2x[33] ? -a2x : a2x;
	assign thrx  = $signed({18'b0, thr_q});
	assign mdiff = m1s - m2s;
	assign mabs  = mdiff[33] ? -mdiff : mdiff;
	assign kdiff = a2x - a1x;
	assign ksum  = a2x + a1x;
	assign u0x   = 34'(u0_q);
	assign dux   = 34'(du_q);

	always_comb begin
		if (m1s <= thrx || m2s <= thrx)
			mode = MODE_ZERO;
		else if (mabs <= thrx)
			mode = MODE_EQUAL;
		else
			mode = MODE_GENERAL;
	end

	assign k_sel = (mode == MODE_EQUAL) ? (m1s <<< 1) : (cmd.track ? ksum : kdiff);

	always_comb begin
		case (cmd.ev)
			EV_U0:   u_sel = u0x;
			EV_U1:   u_sel = u0x + dux;
			EV_U2:   u_sel = u0x + (dux <<< 1);
			default: u_sel = dux;
		endcase
	end

	assign p_sel = cmd.track ? p1_q : p0_q;
	assign q_sel = cmd.track ? q1_q : q0_q;
	assign d_sel = cmd.track ? d1_q : d0_q;
	assign s_sel = cmd.first ? p_sel : q_sel;

	// Sine difference against the previous end point.
	assign st_val = clamp2(40'(sn) - 40'(sprev_q));

	assign rnd = (prod_q + 66'sd536870912) >>> 30;
	assign nx  = clamp2(40'(rnd) - 40'(p_sel));

	assign num = (mode == MODE_EQUAL) ? (42'(s_sel) <<< 8) : (42'(s_sel) <<< 9);
	assign den = (mode == MODE_EQUAL) ? m1s : (cmd.track ? ksum : kdiff);

	assign half = (dux + 34'sd16) >>> 5;
	assign v1   = 45'(half) - 45'(qa_q);
	assign v2   = 45'(qa_q) - 45'(quo);

	always_comb begin
		case (mode)
			MODE_EQUAL:   v = (a1_q[31] ^ a2_q[31]) ? -v1 : v1;
			MODE_GENERAL: v = v2;
			default:      v = '0;
		endcase
	end

	csp_trig u_trig (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.trig_start),
		.k      (k_sel),
		.u      (u_sel),
		.done   (trig_done),
		.sn     (sn),
		.cs     (cs)
	);

	csp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (num),
		.den    (den),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= 16'd1;
			strobe_q <= 1'b0;
		end else begin
			if (cfg_we)
				thr_q <= cfg_data;
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			u0_q <= request.start_angle;
			du_q <= request.step_angle;
			a1_q <= request.freq_one;
			a2_q <= request.freq_two;
		end
		if (cmd.trig_store) begin
			case (cmd.ev)
				EV_U0: sprev_q <= sn;
				EV_U1: begin
					sprev_q <= sn;
					if (cmd.track) p1_q <= st_val; else p0_q <= st_val;
				end
				EV_U2: begin
					if (cmd.track) q1_q <= st_val; else q0_q <= st_val;
				end
				default: begin
					if (cmd.track) d1_q <= clamp2(40'(cs) <<< 1);
					else d0_q <= clamp2(40'(cs) <<< 1);
				end
			endcase
		end
		if (cmd.mul)
			prod_q <= d_sel * q_sel;
		if (cmd.recur) begin
			if (cmd.track) begin
				p1_q <= q1_q;
				q1_q <= nx;
			end else begin
				p0_q <= q0_q;
				q0_q <= nx;
			end
		end
		if (cmd.div_take)
			qa_q <= quo;
		if (cmd.emit) begin
			res_q.integral   <= sat32(v);
			res_q.cell_index <= cmd.cell_idx;
			res_q.last       <= cmd.last;
		end
	end

	assign sts.mode      = mode;
	assign sts.trig_done = trig_done;
	assign sts.div_done  = div_done;
	assign strobe        = strobe_q;
	assign result        = res_q;

endmodule

`default_nettype wire

// File: rtl/core/csp_ctrl.sv
// Controller state machine: sequences setup evaluations, recurrence steps, divisions and result beats.
`default_nettype none

module csp_ctrl import csp_pkg::*; #(
	parameter int MAX_CELLS = MAX_CELLS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic [6:0] cell_count,
	input  wire sts_t       sts,
	output logic            busy,
	output cmd_t            cmd
);

	localparam int CntW = $clog2(MAX_CELLS + 1);

	typedef enum logic [9:0] {
		ST_IDLE      = 10'b0000000001,
		ST_DECIDE    = 10'b0000000010,
		ST_TRIG_GO   = 10'b0000000100,
		ST_TRIG_WAIT = 10'b0000001000,
		ST_CELL      = 10'b0000010000,
		ST_MUL       = 10'b0000100000,
		ST_RECUR     = 10'b0001000000,
		ST_DIV_GO    = 10'b0010000000,
		ST_DIV_WAIT  = 10'b0100000000,
		ST_EMIT      = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic [CntW-1:0] n_q, j_q, n_eff;
	logic tr_q;
	logic [1:0] ev_q;
	logic general, last_cell;

	assign n_eff     = (cell_count > 7'(MAX_CELLS)) ? CntW'(MAX_CELLS) : CntW'(cell_count);
	assign general   = (sts.mode == MODE_GENERAL);
	assign last_cell = ({1'b0, j_q} + 1'b1) == {1'b0, n_q};

	always_comb begin
		cmd          = '0;
		cmd.track    = tr_q;
		cmd.ev       = ev_q;
		cmd.first    = (j_q == '0);
		cmd.cell_idx = 6'(j_q);
		cmd.last     = last_cell;
		state_d      = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (n_eff != '0)
						state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: state_d = (sts.mode == MODE_ZERO) ? ST_CELL : ST_TRIG_GO;
			ST_TRIG_GO: begin
				cmd.trig_start = 1'b1;
				state_d = ST_TRIG_WAIT;
			end
			ST_TRIG_WAIT: begin
				if (sts.trig_done) begin
					cmd.trig_store = 1'b1;
					if (ev_q == EV_DU && !(general && !tr_q))
						state_d = ST_CELL;
					else
						state_d = ST_TRIG_GO;
				end
			end
			ST_CELL: begin
				if (sts.mode == MODE_ZERO)
					state_d = ST_EMIT;
				else if (j_q >= CntW'(2))
					state_d = ST_MUL;
				else
					state_d = ST_DIV_GO;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_RECUR;
			end
			ST_RECUR: begin
				cmd.recur = 1'b1;
				state_d = (general && !tr_q) ? ST_MUL : ST_DIV_GO;
			end
			ST_DIV_GO: begin
				cmd.div_start = 1'b1;
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					cmd.div_take = !tr_q;
					state_d = (general && !tr_q) ? ST_DIV_GO : ST_EMIT;
				end
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d = last_cell ? ST_IDLE : ST_CELL;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			j_q     <= '0;
			tr_q    <= 1'b0;
			ev_q    <= EV_U0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						n_q <= n_eff;
						j_q <= '0;
					end
				end
				ST_DECIDE: begin
					tr_q <= 1'b0;
					ev_q <= EV_U0;
				end
				ST_TRIG_WAIT: begin
					if (sts.trig_done) begin
						if (ev_q == EV_DU) begin
							ev_q <= EV_U0;
							tr_q <= ~tr_q;
						end else begin
							ev_q <= ev_q + 2'd1;
						end
					end
				end
				ST_CELL:  tr_q <= 1'b0;
				ST_RECUR: tr_q <= general && !tr_q;
				ST_DIV_WAIT: begin
					if (sts.div_done)
						tr_q <= general && !tr_q;
				end
				ST_EMIT:  j_q <= j_q + 1'b1;
				default: ;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for the cell integral sine product unit.
`timescale 1ns / 100ps

module testbench;
	import csp_pkg::*;

	// Phase wrap and angle constants of the trig evaluation, Q44 and Q30.
	localparam logic [63:0] WRAP_Q44 = 64'h6487ED5110B5;
	localparam longint ANG_PI = 64'sd3373259426;
	localparam longint ANG_2PI = 64'sd6746518852;
	localparam longint ANG_HALF_PI = 64'sd1686629713;
	localparam longint ANG_QUARTER_PI = 64'sd843314857;
	localparam longint ROT_GAIN = 64'sd652032874;
	localparam longint UNIT_Q30 = 64'sd1073741824;
	localparam int ROT_STEPS = 30;
	localparam int CELL_CAP = 64;

	typedef struct {
		longint prev;
		longint cur;
		longint twocos;
	} sine_track_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	req_t        request;
	logic        strobe;
	res_t        result;
	logic        cfg_we;
	logic [15:0] cfg_data;

	// Predictor state: the threshold as the block should hold it and the rotation angles.
	logic [15:0] near_thr;
	longint      rot_angle [ROT_STEPS];
	res_t        cell_results [$];
	int          mismatches;
	int          send_idle_pct;

	cell_integral_sine_product_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.request  (request),
		.strobe   (strobe),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic longint mag(input longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic longint clip2(input longint v);
		if (v > 2 * UNIT_Q30) return 2 * UNIT_Q30;
		if (v < -2 * UNIT_Q30) return -2 * UNIT_Q30;
		return v;
	endfunction

	function automatic longint sat_word(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Rounded quotient, halves away from zero; a zero divisor gives zero.
	function automatic longint quot_round(input longint n, input longint d);
		longint unsigned q;
		if (d == 0) return 0;
		q = (longint'(mag(n)) + mag(d) / 2) / mag(d);
		return ((n < 0) != (d < 0)) ? -longint'(q) : longint'(q);
	endfunction

	// Sine and cosine of k*u, with k in Q16.16 and u in Q4.28, both results in Q30.
	task automatic sine_cosine(input longint k, input longint u,
			output longint sn, output longint cs);
		logic [127:0] prod;
		logic [63:0]  r;
		longint       t, x, y, z, dx, dy;
		bit           flip;
		flip = 1'b0;
		prod = 128'(mag(k)) * 128'(mag(u));
		r = 64'(prod % 128'(WRAP_Q44));
		if (((k < 0) != (u < 0)) && r != 0)
			r = WRAP_Q44 - r;
		t = longint'((r + 64'd8192) >> 14);
		if (t > ANG_PI) t -= ANG_2PI;
		if (t > ANG_HALF_PI) begin
			t = ANG_PI - t;
			flip = 1'b1;
		end else if (t < -ANG_HALF_PI) begin
			t = -ANG_PI - t;
			flip = 1'b1;
		end
		x = ROT_GAIN;
		y = 0;
		z = t;
		for (int i = 0; i < ROT_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= rot_angle[i];
			end else begin
				x += dx;
				y -= dy;
				z += rot_angle[i];
			end
		end
		sn = y;
		cs = flip ? -x : x;
	endtask

	task automatic track_setup(output sine_track_t tr, input longint k,
			input longint u0, input longint du);
		longint s0, s1, s2, c, d;
		sine_cosine(k, u0, s0, c);
		sine_cosine(k, u0 + du, s1, c);
		sine_cosine(k, u0 + 2 * du, s2, c);
		sine_cosine(k, du, c, d);
		tr.twocos = clip2(2 * d);
		tr.prev = clip2(s1 - s0);
		tr.cur = clip2(s2 - s1);
	endtask

	// Sine difference across cell j; cells must be taken in order.
	function automatic longint track_next(inout sine_track_t tr, input int j);
		longint nx;
		if (j == 0) return tr.prev;
		if (j >= 2) begin
			nx = clip2(((tr.twocos * tr.cur + (64'sd1 <<< 29)) >>> 30) - tr.prev);
			tr.prev = tr.cur;
			tr.cur = nx;
		end
		return tr.cur;
	endfunction

	// Works out every cell integral of an accepted request and queues them.
	task automatic predict_cells(input req_t rq);
		longint      u0, du, a1, a2, m1, m2, thr, v;
		int          n;
		mode_t       md;
		sine_track_t t1, t2;
		res_t        r;
		u0 = rq.start_angle;
		du = rq.step_angle;
		a1 = rq.freq_one;
		a2 = rq.freq_two;
		m1 = mag(a1);
		m2 = mag(a2);
		thr = near_thr;
		n = rq.cell_count > CELL_CAP ? CELL_CAP : rq.cell_count;
		if (m1 <= thr || m2 <= thr)
			md = MODE_ZERO;
		else if (mag(m1 - m2) <= thr)
			md = MODE_EQUAL;
		else
			md = MODE_GENERAL;
		if (md == MODE_EQUAL)
			track_setup(t1, 2 * m1, u0, du);
		else if (md == MODE_GENERAL) begin
			track_setup(t1, a2 - a1, u0, du);
			track_setup(t2, a2 + a1, u0, du);
		end
		for (int j = 0; j < n; j++) begin
			v = 0;
			if (md == MODE_EQUAL) begin
				v = ((du + 16) >>> 5) - quot_round(track_next(t1, j) * 256, m1);
				if ((a1 < 0) != (a2 < 0)) v = -v;
			end else if (md == MODE_GENERAL) begin
				v = quot_round(track_next(t1, j) * 512, a2 - a1)
					- quot_round(track_next(t2, j) * 512, a2 + a1);
			end
			r.integral = 32'(sat_word(v));
			r.cell_index = 6'(j);
			r.last = (j + 1 == n);
			cell_results.push_back(r);
		end
	endtask

	// Every result beat is compared with the oldest expected cell.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (cell_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %0d idx %0d last %0b",
						result.integral, result.cell_index, result.last);
			end else begin
				if (result.integral !== cell_results[0].integral
						|| result.cell_index !== cell_results[0].cell_index
						|| result.last !== cell_results[0].last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %0d idx %0d last %0b, got %0d idx %0d last %0b",
							cell_results[0].integral, cell_results[0].cell_index,
							cell_results[0].last, result.integral, result.cell_index,
							result.last);
				end
				void'(cell_results.pop_front());
			end
		end
	end

	// Sends one request beat and holds it until the block takes it.
	task automatic send_request(input req_t rq);
		request <= rq;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		predict_cells(rq);
		if ($urandom_range(99) < send_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	endtask

	// Stops sending until every expected cell is back, then lets a request that
	// yields no cells finish as well.
	task automatic drain;
		start <= 1'b0;
		while (cell_results.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_threshold(input logic [15:0] v);
		drain();
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(posedge clk);
		cfg_we <= 1'b0;
		near_thr = v;
	endtask

	function automatic req_t make_req(input longint u0, input longint du, input int n,
			input longint f1, input longint f2);
		req_t rq;
		rq.start_angle = 32'(u0);
		rq.step_angle = 32'(du);
		rq.cell_count = 7'(n);
		rq.freq_one = 32'(f1);
		rq.freq_two = 32'(f2);
		return rq;
	endfunction

	function automatic int rand_count();
		int p;
		p = $urandom_range(99);
		if (p < 80) return $urandom_range(1, 6);
		if (p < 90) return $urandom_range(7, 20);
		if (p < 95) return 64;
		if (p < 98) return $urandom_range(65, 127);
		return 0;
	endfunction

	// Frequencies span tiny to full scale so that every bit gets exercised.
	function automatic longint rand_freq_mag();
		case ($urandom_range(2))
			0: return $urandom_range(0, 32'h000FFFFF);
			1: return $urandom_range(0, 32'h00FFFFFF);
			default: return $urandom_range(0, 32'h7FFE0000);
		endcase
	endfunction

	function automatic longint rand_angle();
		if ($urandom_range(1)) return longint'($signed($urandom()));
		return longint'($signed($urandom_range(0, 32'h3FFFFFF))) - 64'sd33554432;
	endfunction

	function automatic req_t rand_req();
		longint thr, f1, f2, m1;
		int     p;
		thr = near_thr;
		p = $urandom_range(99);
		f1 = rand_freq_mag();
		if ($urandom_range(1)) f1 = -f1;
		if (p < 5) begin
			// Noise: both frequencies fully random.
			f1 = longint'($signed($urandom()));
			f2 = longint'($signed($urandom()));
		end else if (p < 20) begin
			// One frequency within the threshold of zero.
			f2 = longint'($urandom_range(0, 32'(thr)));
			if ($urandom_range(1)) f2 = -f2;
			if ($urandom_range(1)) begin
				m1 = f1;
				f1 = f2;
				f2 = m1;
			end
		end else if (p < 45) begin
			// Magnitudes within the threshold of each other.
			m1 = mag(f1);
			if (m1 <= thr) m1 = thr + 1 + $urandom_range(0, 1000);
			f1 = f1 < 0 ? -m1 : m1;
			f2 = m1 + longint'($urandom_range(0, 32'(2 * thr))) - thr;
			if ($urandom_range(1)) f2 = -f2;
		end else begin
			f2 = rand_freq_mag();
			if ($urandom_range(1)) f2 = -f2;
		end
		return make_req(rand_angle(), rand_angle(), rand_count(), f1, f2);
	endfunction

	task automatic test_directed;
		send_idle_pct = 0;
		send_request(make_req(0, 64'sd26843546, 4, 64'sd65536, 64'sd131072));
		send_request(make_req(-64'sd2147483648, 64'sd2147483647, 3,
			64'sd2147483647, -64'sd2147483648));
		send_request(make_req(64'sd2147483647, -64'sd2147483648, 3,
			-64'sd2147483648, 64'sd2147483647));
		send_request(make_req(64'sd1000, 64'sd268435456, 2, 0, 64'sd65536));
		send_request(make_req(64'sd1000, 64'sd268435456, 2, 64'sd65536, 1));
		send_request(make_req(64'sd5000, 64'sd134217728, 5, 64'sd65536, 64'sd65536));
		send_request(make_req(64'sd5000, 64'sd134217728, 5, 64'sd65536, -64'sd65537));
		send_request(make_req(-64'sd5000, -64'sd134217728, 5, -64'sd98304, -64'sd98304));
		send_request(make_req(0, 64'sd10000000, 0, 64'sd65536, 64'sd200000));
		send_request(make_req(0, 64'sd10000000, 1, 64'sd65536, 64'sd200000));
		send_request(make_req(0, 64'sd10000000, 64, 64'sd65536, 64'sd200000));
		send_request(make_req(0, 64'sd10000000, 127, 64'sd3000000, -64'sd70000));
		send_request(make_req(0, 64'sd10000000, 65, 0, 0));
		send_request(make_req(0, 0, 3, 64'sd65536, 64'sd131072));
		send_request(make_req(64'sd12345678, 64'sd100000, 6, -64'sd2147483648,
			-64'sd2147483648));
		send_request(make_req(-64'sd1, -64'sd1, 6, -64'sd1, 64'sd2));
	endtask

	// Runs random requests at one threshold and one sender idling rate.
	task automatic test_random_phase(input logic [15:0] thr, input int pct, input int count);
		write_threshold(thr);
		send_idle_pct = pct;
		for (int i = 0; i < count; i++)
			send_request(rand_req());
	endtask

	// Pauses with nothing in flight between two requests.
	task automatic test_quiet_gap;
		send_idle_pct = 0;
		send_request(rand_req());
		drain();
		send_request(rand_req());
	endtask

	initial begin
		longint acc, term;
		for (int i = 0; i < ROT_STEPS; i++) begin
			if (i == 0) begin
				rot_angle[i] = ANG_QUARTER_PI;
			end else begin
				acc = 0;
				for (int n = 0; i * (2 * n + 1) <= 62; n++) begin
					term = (64'sd1 <<< (62 - i * (2 * n + 1))) / longint'(2 * n + 1);
					acc = n[0] ? acc - term : acc + term;
				end
				rot_angle[i] = longint'((64'(acc) + (64'd1 << 31)) >> 32);
			end
		end
		near_thr = 16'd1;
		mismatches = 0;
		send_idle_pct = 0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_quiet_gap();
		test_random_phase(16'd0, 0, 120);
		test_random_phase(16'hFFFF, 70, 120);
		test_random_phase(16'd1, 0, 120);
		test_random_phase(16'($urandom_range(2, 16'hFFFE)), 16, 140);

		drain();
		if (mismatches == 0 && cell_results.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#1_000_000_000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
